### hw/rtl/afbd_pkg.sv
// ----------------------------------------------------------------------------
// afbd_pkg - shared types and constants of the frame block deframer
// Phase codes, block kinds and controller commands.
// ----------------------------------------------------------------------------
package afbd_pkg;

  localparam int unsigned RateNum = 1000000;

  localparam logic [7:0] KindVideo   = 8'h01;
  localparam logic [7:0] KindAudio   = 8'h02;
  localparam logic [7:0] KindPalette = 8'h03;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusEos  = 2'd1;
  localparam logic [1:0] StatusPal2 = 2'd2;

  localparam logic CfgVideo = 1'b0;
  localparam logic CfgAudio = 1'b1;

  // phase codes kept in the datapath
  typedef enum logic [3:0] {
    PH_FW0  = 4'd0,
    PH_FW1  = 4'd1,
    PH_FS0  = 4'd2,
    PH_FS1  = 4'd3,
    PH_BH   = 4'd4,
    PH_VID  = 4'd5,
    PH_PAL  = 4'd6,
    PH_AUD  = 4'd7,
    PH_AHDR = 4'd8,
    PH_SKIP = 4'd9
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        out_stream;
    logic        last_of_packet;
    logic [31:0] video_stamp;
    logic [1:0]  status;
    logic [19:0] sample_rate;
    logic        rate_valid;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic step;      // process the held item
    logic slot;      // which queued result goes out
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] count; // results made by the last step
  } stat_t;

endpackage

### hw/rtl/afbd_ctrl.sv
// ----------------------------------------------------------------------------
// afbd_ctrl - handshake controller
// Takes one item, lets the datapath work it, then hands out its results.
// ----------------------------------------------------------------------------
module afbd_ctrl import afbd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid,
  output logic  stall,
  output logic  out_valid,
  input  logic  out_stall,
  output cmd_t  cmd,
  input  stat_t st
);

  typedef enum logic [3:0] {
    S_TAKE = 4'b0001,
    S_WORK = 4'b0010,
    S_OUT0 = 4'b0100,
    S_OUT1 = 4'b1000
  } state_t;

  state_t state, state_next;

  assign stall     = (state != S_TAKE);
  assign out_valid = (state == S_OUT0) || (state == S_OUT1);
  assign cmd.step  = (state == S_WORK);
  assign cmd.slot  = (state == S_OUT1);

  // advance through take, work and delivery
  always_comb begin
    state_next = state;
    unique case (state)
      S_TAKE: if (valid) state_next = S_WORK;
      S_WORK: begin
        if (st.count == 2'd0) state_next = S_TAKE;
        else state_next = S_OUT0;
      end
      S_OUT0: if (!out_stall) begin
        if (st.count == 2'd2) state_next = S_OUT1;
        else state_next = S_TAKE;
      end
      S_OUT1: if (!out_stall) state_next = S_TAKE;
      default: state_next = S_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_TAKE;
    else state <= state_next;
  end

endmodule

### hw/rtl/afbd_dp.sv
// ----------------------------------------------------------------------------
// afbd_dp - deframer datapath
// Holds the parse state, works one byte per step and queues its results.
// ----------------------------------------------------------------------------
module afbd_dp import afbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic       cfg_bad,
  input  logic       cfg_bit,
  input  cmd_t       cmd,
  output stat_t      st,
  output result_t    res
);

  logic video_enable, audio_enable;
  logic [7:0] b;
  phase_t phase, phase_n;
  logic [15:0] fcount, fcount_n, flen, flen_n, bleft, bleft_n;
  logic [2:0] hidx, hidx_n;
  logic [7:0] held, held_n, kind, kind_n;
  logic [23:0] ahw, ahw_n, aleft, aleft_n;
  logic aopen, aopen_n, vopen, vopen_n, rknown, rknown_n, halted, halted_n;
  logic [31:0] stamp, stamp_n;
  result_t r0, r1, q0, q1;
  logic [1:0] n, cnt;
  logic [15:0] bsz;
  logic [19:0] rate_reg;
  logic [255:0][19:0] rate_tab;

  // sample rate for every divisor value, fixed at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_rate
    localparam logic [19:0] Rate = 20'(RateNum / (256 - g));
    assign rate_tab[g] = Rate;
  end

  // hold the accepted byte and its rate lookup
  always_ff @(posedge clk) begin
    if (take) begin
      b <= in_byte;
      rate_reg <= rate_tab[in_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      video_enable <= 1'b1;
      audio_enable <= 1'b1;
    end else if (cfg_we && !cfg_bad) begin
      if (cfg_idx == CfgVideo) video_enable <= cfg_bit;
      else audio_enable <= cfg_bit;
    end
  end

  function automatic result_t mk(input logic [7:0] by, input logic v, input logic s,
                                 input logic l, input logic [31:0] sp,
                                 input logic [1:0] stt, input logic [19:0] rt,
                                 input logic rv);
    result_t x;
    x.out_byte = by; x.byte_valid = v; x.out_stream = s; x.last_of_packet = l;
    x.video_stamp = sp; x.status = stt; x.sample_rate = rt; x.rate_valid = rv;
    return x;
  endfunction

  // work one byte
  always_comb begin
    logic [2:0] idx;
    logic nop;
    phase_n = phase; fcount_n = fcount; flen_n = flen; bleft_n = bleft;
    hidx_n = hidx; held_n = held; kind_n = kind; ahw_n = ahw; aleft_n = aleft;
    aopen_n = aopen; vopen_n = vopen; rknown_n = rknown; halted_n = halted;
    stamp_n = stamp; n = 2'd0; r0 = '0; r1 = '0; bsz = '0; idx = '0; nop = 1'b0;
    if (!halted) begin
      if (phase == PH_FW0) fcount_n = 16'd1;
      else if (fcount != 16'hFFFF) fcount_n = fcount + 16'd1;
      case (phase)
        PH_FW0: begin held_n = b; phase_n = PH_FW1; end
        PH_FW1: begin
          if (held == 8'd0 && b == 8'd0) begin
            r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, '0, StatusEos, '0, 1'b0);
            n = 2'd1; halted_n = 1'b1;
          end else phase_n = PH_FS0;
        end
        PH_FS0: begin held_n = b; phase_n = PH_FS1; end
        PH_FS1: begin
          flen_n = {b, held};
          phase_n = PH_BH;
          hidx_n = '0;
          if (!(fcount_n < flen_n)) phase_n = PH_FW0;
          nop = 1'b1;
        end
        PH_BH: begin
          idx = {1'b0, hidx[1:0]};
          hidx_n = idx + 3'd1;
          if (idx == 3'd0) held_n = b;
          else if (idx == 3'd1) begin
            kind_n = b;
            if (b == KindVideo || b == KindPalette) begin
              if (!video_enable) kind_n = '0;
              else if (b == KindPalette && vopen) begin
                r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, '0, StatusPal2, '0, 1'b0);
                n = 2'd1; halted_n = 1'b1;
              end else begin
                vopen_n = 1'b1;
                r0 = mk(held, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
                r1 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
                n = 2'd2;
              end
            end else if (b == KindAudio && !audio_enable) kind_n = '0;
          end else if (idx == 3'd2) begin
            bleft_n = {8'd0, b};
            if (kind == KindVideo || kind == KindPalette) begin
              r0 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
              n = 2'd1;
            end
          end else begin
            bsz = {b, bleft[7:0]};
            bleft_n = (bsz < 16'd4) ? 16'd0 : bsz - 16'd4;
            if (kind == KindVideo) begin
              if (bleft_n == 16'd0) begin
                r0 = mk(b, 1'b1, 1'b0, 1'b1, stamp, StatusOk, '0, 1'b0);
                n = 2'd1; stamp_n = stamp + 32'd1; vopen_n = 1'b0;
                nop = 1'b1;
              end else begin
                r0 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
                n = 2'd1; phase_n = PH_VID;
              end
            end else if (kind == KindPalette) begin
              r0 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
              n = 2'd1;
              if (bleft_n == 16'd0) nop = 1'b1; else phase_n = PH_PAL;
            end else if (kind == KindAudio) begin
              if (bleft_n == 16'd0) nop = 1'b1;
              else if (aopen) phase_n = PH_AUD;
              else if (bleft_n < 16'd6) phase_n = PH_SKIP;
              else begin phase_n = PH_AHDR; hidx_n = '0; end
            end else begin
              if (bleft_n == 16'd0) nop = 1'b1; else phase_n = PH_SKIP;
            end
          end
        end
        PH_VID: begin
          bleft_n = bleft - 16'd1;
          if (bleft_n == 16'd0) begin
            r0 = mk(b, 1'b1, 1'b0, 1'b1, stamp, StatusOk, '0, 1'b0);
            stamp_n = stamp + 32'd1; vopen_n = 1'b0; nop = 1'b1;
          end else r0 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
          n = 2'd1;
        end
        PH_PAL: begin
          r0 = mk(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
          n = 2'd1; bleft_n = bleft - 16'd1;
          if (bleft_n == 16'd0) nop = 1'b1;
        end
        PH_AHDR: begin
          idx = hidx;
          hidx_n = idx + 3'd1;
          bleft_n = bleft - 16'd1;
          if (idx == 3'd0) ahw_n = '0;
          else if (idx == 3'd1) ahw_n[7:0] = b;
          else if (idx == 3'd2) ahw_n[15:8] = b;
          else if (idx == 3'd3) ahw_n[23:16] = b;
          else if (idx == 3'd4) begin
            if (!rknown) begin
              rknown_n = 1'b1;
              r0 = mk(8'd0, 1'b0, 1'b1, 1'b0, '0, StatusOk, rate_reg, 1'b1);
              n = 2'd1;
            end
          end else begin
            aleft_n = (ahw < 24'd2) ? 24'd0 : ahw - 24'd2;
            aopen_n = 1'b1;
            if (aleft_n == 24'd0) begin
              r0 = mk(8'd0, 1'b0, 1'b1, 1'b1, '0, StatusOk, '0, 1'b0);
              n = 2'd1; aopen_n = 1'b0;
            end
            if (bleft_n == 16'd0) nop = 1'b1;
            else if (aopen_n) phase_n = PH_AUD;
            else if (bleft_n < 16'd6) phase_n = PH_SKIP;
            else begin phase_n = PH_AHDR; hidx_n = '0; end
          end
        end
        PH_AUD: begin
          aleft_n = aleft - 24'd1;
          bleft_n = bleft - 16'd1;
          if (aleft_n == 24'd0) begin
            r0 = mk(b, 1'b1, 1'b1, 1'b1, '0, StatusOk, '0, 1'b0);
            aopen_n = 1'b0;
          end else r0 = mk(b, 1'b1, 1'b1, 1'b0, '0, StatusOk, '0, 1'b0);
          n = 2'd1;
          if (bleft_n == 16'd0) nop = 1'b1;
          else if (aopen_n) phase_n = PH_AUD;
          else if (bleft_n < 16'd6) phase_n = PH_SKIP;
          else begin phase_n = PH_AHDR; hidx_n = '0; end
        end
        PH_SKIP: begin
          bleft_n = bleft - 16'd1;
          if (bleft_n == 16'd0) nop = 1'b1;
        end
        default: phase_n = PH_FW0;
      endcase
      // end of block: next block or next frame
      if (nop) begin
        if (fcount_n < flen_n) begin phase_n = PH_BH; hidx_n = '0; end
        else phase_n = PH_FW0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FW0; fcount <= '0; flen <= '0; bleft <= '0; hidx <= '0;
      held <= '0; kind <= '0; ahw <= '0; aleft <= '0; aopen <= 1'b0;
      vopen <= 1'b0; rknown <= 1'b0; halted <= 1'b0; stamp <= '0; cnt <= '0;
    end else if (cmd.step) begin
      phase <= phase_n; fcount <= fcount_n; flen <= flen_n; bleft <= bleft_n;
      hidx <= hidx_n; held <= held_n; kind <= kind_n; ahw <= ahw_n;
      aleft <= aleft_n; aopen <= aopen_n; vopen <= vopen_n; rknown <= rknown_n;
      halted <= halted_n; stamp <= stamp_n; cnt <= n;
    end
  end

  // queue the results of the step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      q0 <= r0;
      q1 <= r1;
    end
  end

  assign st.count = cmd.step ? n : cnt;
  assign res = cmd.slot ? q1 : q0;

endmodule

### hw/rtl/avs_frame_block_deframer.sv
// ----------------------------------------------------------------------------
// avs_frame_block_deframer - frame and block parser of a game video stream
// Splits the frame stream into video and audio packet bytes with markers.
// ----------------------------------------------------------------------------
// Input channel: valid/stall carrying in_byte, one stream byte per item,
// starting after the file header. Output channel: valid/stall carrying one
// result item (byte or marker) per handshake.
// Each byte passes the take and work states (accept, then one step of the parser
// state), then a delivery state for each result, held while the receiver stalls;
// a byte makes 0, 1 or 2 results. The single-step controller takes no new
// byte before the results of the last one are delivered.
// The sample-rate divide is a constant table read when the byte is taken.
// Reset sets both enables, clears all parse state and empties the output.
// While the receiver stalls, the current result holds and no new byte is
// taken. After end of stream or a second palette the block drops all bytes.
// Configuration: cfg_we/cfg_index/cfg_data; the user writes it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module avs_frame_block_deframer import afbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_stream,
  output logic        last_of_packet,
  output logic [31:0] video_stamp,
  output logic [1:0]  status,
  output logic [19:0] sample_rate,
  output logic        rate_valid,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data
);

  cmd_t    cmd;
  stat_t   st;
  result_t res;

  afbd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .st(st)
  );

  afbd_dp u_dp (
    .clk(clk), .rst(rst), .take(in_valid && !in_stall), .in_byte(in_byte),
    .cfg_we(cfg_we), .cfg_idx(cfg_index[0]), .cfg_bad(1'b0), .cfg_bit(cfg_data[0]),
    .cmd(cmd), .st(st), .res(res)
  );

  assign out_byte       = res.out_byte;
  assign byte_valid     = res.byte_valid;
  assign out_stream     = res.out_stream;
  assign last_of_packet = res.last_of_packet;
  assign video_stamp    = res.video_stamp;
  assign status         = res.status;
  assign sample_rate    = res.sample_rate;
  assign rate_valid     = res.rate_valid;

endmodule

### tb/avs_frame_block_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// avs_frame_block_deframer_tb - self-checking bench of the frame deframer
// Drives frames with random blocks, audio sub-headers and
// payloads. A local parser predicts every result item, and each delivered
// item is checked field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module avs_frame_block_deframer_tb;
  import afbd_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        out_stream;
  logic        last_of_packet;
  logic [31:0] video_stamp;
  logic [1:0]  status;
  logic [19:0] sample_rate;
  logic        rate_valid;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [0:0]  cfg_data;

  avs_frame_block_deframer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .out_stream(out_stream),
    .last_of_packet(last_of_packet), .video_stamp(video_stamp),
    .status(status), .sample_rate(sample_rate), .rate_valid(rate_valid),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // parser state mirrored from the block
  phase_t      p_phase;
  logic [15:0] frm_count, frm_len, blk_left;
  logic [2:0]  hdr_idx;
  logic [7:0]  held, kind;
  logic [23:0] ahdr_word, aud_left;
  logic        aud_open, vid_open, rate_known, halted;
  logic [31:0] stamp_cnt;
  logic        en_video, en_audio;

  result_t     pending_q[$];
  result_t     last_made;
  int          errors;
  int          tx_idle_pct, rx_stall_pct, rx_hold;
  int          bytes_sent;

  function void make(input logic [7:0] b, input logic v, input logic s, input logic l,
                     input logic [31:0] st, input logic [1:0] sts,
                     input logic [19:0] r, input logic rv);
    result_t e;
    e = '{b, v, s, l, st, sts, r, rv};
    pending_q.push_back(e);
    last_made = e;
  endfunction

  function void close_block();
    if (frm_count < frm_len) begin
      p_phase = PH_BH;
      hdr_idx = 3'd0;
    end else begin
      p_phase = PH_FW0;
    end
  endfunction

  function void begin_skip();
    if (blk_left == 16'd0) close_block();
    else p_phase = PH_SKIP;
  endfunction

  function void audio_next();
    if (blk_left == 16'd0) close_block();
    else if (aud_open) p_phase = PH_AUD;
    else if (blk_left < 16'd6) begin_skip();
    else begin
      p_phase = PH_AHDR;
      hdr_idx = 3'd0;
    end
  endfunction

  // work out the results of one accepted stream byte
  function void parse_byte(input logic [7:0] b);
    logic [2:0] idx;
    logic       vid;
    int         r;
    if (halted) return;
    if (p_phase == PH_FW0) frm_count = 16'd1;
    else if (frm_count != 16'hFFFF) frm_count = frm_count + 16'd1;
    case (p_phase)
      PH_FW0: begin
        held = b;
        p_phase = PH_FW1;
      end
      PH_FW1: begin
        if ({b, held} == 16'd0) begin
          make(8'd0, 1'b0, 1'b0, 1'b0, '0, StatusEos, '0, 1'b0);
          halted = 1'b1;
        end else p_phase = PH_FS0;
      end
      PH_FS0: begin
        held = b;
        p_phase = PH_FS1;
      end
      PH_FS1: begin
        frm_len = {b, held};
        close_block();
      end
      PH_BH: begin
        idx = {1'b0, hdr_idx[1:0]};
        hdr_idx = idx + 3'd1;
        if (idx == 3'd0) held = b;
        else if (idx == 3'd1) begin
          kind = b;
          if (b == KindVideo || b == KindPalette) begin
            if (!en_video) kind = 8'd0;
            else if (b == KindPalette && vid_open) begin
              make(8'd0, 1'b0, 1'b0, 1'b0, '0, StatusPal2, '0, 1'b0);
              halted = 1'b1;
            end else begin
              vid_open = 1'b1;
              make(held, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
              make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
            end
          end else if (b == KindAudio && !en_audio) kind = 8'd0;
        end else begin
          vid = (kind == KindVideo || kind == KindPalette);
          if (idx == 3'd2) begin
            blk_left = {8'd0, b};
            if (vid) make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
          end else begin
            blk_left = {b, blk_left[7:0]};
            blk_left = (blk_left < 16'd4) ? 16'd0 : blk_left - 16'd4;
            if (kind == KindVideo) begin
              if (blk_left == 16'd0) begin
                make(b, 1'b1, 1'b0, 1'b1, stamp_cnt, StatusOk, '0, 1'b0);
                stamp_cnt = stamp_cnt + 32'd1;
                vid_open = 1'b0;
                close_block();
              end else begin
                make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
                p_phase = PH_VID;
              end
            end else if (kind == KindPalette) begin
              make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
              if (blk_left == 16'd0) close_block();
              else p_phase = PH_PAL;
            end else if (kind == KindAudio) audio_next();
            else begin_skip();
          end
        end
      end
      PH_VID: begin
        blk_left = blk_left - 16'd1;
        if (blk_left == 16'd0) begin
          make(b, 1'b1, 1'b0, 1'b1, stamp_cnt, StatusOk, '0, 1'b0);
          stamp_cnt = stamp_cnt + 32'd1;
          vid_open = 1'b0;
          close_block();
        end else make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
      end
      PH_PAL: begin
        make(b, 1'b1, 1'b0, 1'b0, '0, StatusOk, '0, 1'b0);
        blk_left = blk_left - 16'd1;
        if (blk_left == 16'd0) close_block();
      end
      PH_AHDR: begin
        idx = hdr_idx;
        hdr_idx = idx + 3'd1;
        blk_left = blk_left - 16'd1;
        if (idx == 3'd0) ahdr_word = 24'd0;
        else if (idx <= 3'd3) ahdr_word = ahdr_word | (24'(b) << (8 * (idx - 3'd1)));
        else if (idx == 3'd4) begin
          if (!rate_known) begin
            rate_known = 1'b1;
            r = 1000000 / (256 - int'(b));
            make(8'd0, 1'b0, 1'b1, 1'b0, '0, StatusOk, 20'(r), 1'b1);
          end
        end else begin
          aud_left = (ahdr_word < 24'd2) ? 24'd0 : ahdr_word - 24'd2;
          aud_open = 1'b1;
          if (aud_left == 24'd0) begin
            make(8'd0, 1'b0, 1'b1, 1'b1, '0, StatusOk, '0, 1'b0);
            aud_open = 1'b0;
          end
          audio_next();
        end
      end
      PH_AUD: begin
        aud_left = aud_left - 24'd1;
        blk_left = blk_left - 16'd1;
        if (aud_left == 24'd0) begin
          make(b, 1'b1, 1'b1, 1'b1, '0, StatusOk, '0, 1'b0);
          aud_open = 1'b0;
        end else make(b, 1'b1, 1'b1, 1'b0, '0, StatusOk, '0, 1'b0);
        audio_next();
      end
      PH_SKIP: begin
        blk_left = blk_left - 16'd1;
        if (blk_left == 16'd0) close_block();
      end
      default: p_phase = PH_FW0;
    endcase
  endfunction

  task automatic field_check(input string name, input logic [31:0] e, input logic [31:0] g);
    if (e !== g) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
      errors++;
    end
  endtask

  task automatic result_check(input result_t e, input result_t g);
    field_check("out_byte", 32'(e.out_byte), 32'(g.out_byte));
    field_check("byte_valid", 32'(e.byte_valid), 32'(g.byte_valid));
    field_check("out_stream", 32'(e.out_stream), 32'(g.out_stream));
    field_check("last_of_packet", 32'(e.last_of_packet), 32'(g.last_of_packet));
    field_check("video_stamp", e.video_stamp, g.video_stamp);
    field_check("status", 32'(e.status), 32'(g.status));
    field_check("sample_rate", 32'(e.sample_rate), 32'(g.sample_rate));
    field_check("rate_valid", 32'(e.rate_valid), 32'(g.rate_valid));
  endtask

  // receiver: stall at random, or hold off for a counted stretch
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // check each delivered item against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_byte, byte_valid, out_stream, last_of_packet, video_stamp,
              status, sample_rate, rate_valid};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        result_check(pending_q.pop_front(), got);
      end
    end
  end

  // offer one byte, with random idle cycles first, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_byte = 8'($urandom);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_byte = b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    bytes_sent++;
  endtask

  // wait until every prediction has arrived, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_enables(input logic v, input logic a);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CfgVideo;
    cfg_data = v;
    en_video = v;
    @(negedge clk);
    cfg_index = CfgAudio;
    cfg_data = a;
    en_audio = a;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // pick a payload byte; keep audio sub-header sizes small most of the time
  function automatic logic [7:0] payload_byte();
    if (p_phase == PH_AHDR) begin
      case (hdr_idx)
        3'd1: return ($urandom_range(99) < 3) ? 8'($urandom) : 8'($urandom_range(0, 30));
        3'd2: return ($urandom_range(99) < 2) ? 8'($urandom) : 8'd0;
        3'd3: return 8'd0;
        default: return 8'($urandom);
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic send_frame();
    int nb, flen, lastc, r;
    int lens[5];
    logic [7:0] k;
    nb = $urandom_range(0, 4);
    flen = 4;
    lastc = 4;
    for (int i = 0; i < nb; i++) begin
      r = $urandom_range(99);
      if (r < 8) lens[i] = $urandom_range(0, 3);
      else if (r < 90) lens[i] = $urandom_range(4, 24);
      else lens[i] = $urandom_range(25, 60);
      lastc = (lens[i] < 4) ? 4 : lens[i];
      flen += lastc;
    end
    // let the last block run past the frame size now and then
    if (nb > 0 && $urandom_range(3) == 0) flen -= $urandom_range(0, lastc - 1);
    r = $urandom_range(1, 65535);
    send_byte(8'(r));
    send_byte(8'(r >> 8));
    send_byte(8'(flen));
    send_byte(8'(flen >> 8));
    for (int i = 0; i < nb; i++) begin
      send_byte(8'($urandom));
      r = $urandom_range(99);
      if (r < 30) k = KindVideo;
      else if (r < 60) k = KindAudio;
      else if (r < 72) k = KindPalette;
      else k = 8'($urandom);
      // avoid the halting second palette until the end of the run
      if (k == KindPalette && vid_open && en_video) k = KindVideo;
      send_byte(k);
      send_byte(8'(lens[i]));
      send_byte(8'(lens[i] >> 8));
      for (int j = 4; j < lens[i]; j++) send_byte(payload_byte());
    end
  endtask

  // directed stream: one stream byte per row, some rows with a typed result
  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    res;
  } row_t;
  row_t rows[$];

  task automatic add_row(input logic [7:0] b);
    rows.push_back('{b, 1'b0, '0});
  endtask

  task automatic add_typed(input logic [7:0] b, input result_t r);
    rows.push_back('{b, 1'b1, r});
  endtask

  task automatic build_rows();
    // frame word 1, size 30
    add_row(8'h01); add_row(8'h00); add_row(8'h1e); add_row(8'h00);
    // video block with one payload byte, closed with stamp 0
    add_row(8'haa); add_row(KindVideo); add_row(8'h05); add_row(8'h00);
    add_typed(8'hff, '{8'hff, 1'b1, 1'b0, 1'b1, 32'd0, StatusOk, 20'd0, 1'b0});
    // empty palette opens a video packet
    add_row(8'h00); add_row(KindPalette); add_row(8'h04); add_row(8'h00);
    // short block size, saturated: empty video closes on its header
    add_row(8'h00); add_row(KindVideo); add_row(8'h02);
    add_typed(8'h00, '{8'h00, 1'b1, 1'b0, 1'b1, 32'd1, StatusOk, 20'd0, 1'b0});
    // audio block: sub-header of size 3, first divisor, one byte, short rest
    add_row(8'h11); add_row(KindAudio); add_row(8'h0d); add_row(8'h00);
    add_row(8'h00); add_row(8'h03); add_row(8'h00); add_row(8'h00);
    add_typed(8'h00, '{8'h00, 1'b0, 1'b1, 1'b0, 32'd0, StatusOk, 20'd3906, 1'b1});
    add_row(8'h00);
    add_typed(8'h7e, '{8'h7e, 1'b1, 1'b1, 1'b1, 32'd0, StatusOk, 20'd0, 1'b0});
    add_row(8'hff); add_row(8'h80);
    // frames with no blocks at all
    add_row(8'hff); add_row(8'hff); add_row(8'h04); add_row(8'h00);
    add_row(8'h00); add_row(8'h80); add_row(8'h01); add_row(8'h00);
  endtask

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int ph;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'd0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgVideo;
    cfg_data = 1'b0;
    errors = 0;
    bytes_sent = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 0;
    en_video = 1'b1;
    en_audio = 1'b1;
    p_phase = PH_FW0;
    {frm_count, frm_len, blk_left, hdr_idx, held, kind} = '0;
    {ahdr_word, aud_left, aud_open, vid_open, stamp_cnt, rate_known, halted} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset settings
    build_rows();
    foreach (rows[i]) begin
      send_byte(rows[i].b);
      if (rows[i].typed && last_made !== rows[i].res) begin
        $display("%0t: predicted %h, expected %h", $time, last_made, rows[i].res);
        errors++;
      end
    end

    // random part: idle mode and enables move on together
    ph = 0;
    while (bytes_sent < 700) begin
      set_enables(ph[2:0] != 3'd1 && ph[2:0] != 3'd3, ph[2:0] != 3'd2 && ph[2:0] != 3'd3);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      // long hold-off while bytes keep coming, so the block fills up
      if (ph == 4) begin
        @(negedge clk);
        rx_hold = 300;
      end
      for (int start = bytes_sent; bytes_sent - start < 90; ) send_frame();
      ph++;
    end

    // close the run with end of stream or a second palette, then noise
    set_enables(1'b1, 1'b1);
    if ($urandom_range(1) == 0) begin
      send_byte(8'h00);
      send_byte(8'h00);
    end else begin
      send_byte(8'h01); send_byte(8'h00); send_byte(8'h0c); send_byte(8'h00);
      send_byte(8'h00); send_byte(KindPalette); send_byte(8'h04); send_byte(8'h00);
      send_byte(8'h00); send_byte(KindPalette);
    end
    repeat (5) send_byte(8'($urandom));

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
